[rtl/ols_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Shared codes and types for the ordered list store: request kinds, result
// status codes and the control word handed to the row of storage cells.
// ----------------------------------------------------------------------------
package ols_pkg;

	localparam int unsigned DataW = 32;

	// request kinds
	localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [1:0] KIND_DELETE     = 2'd2;
	localparam logic [1:0] KIND_LIST       = 2'd3;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DELETED  = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;
	localparam logic [2:0] ST_LISTED   = 3'd5;

	typedef logic signed [DataW-1:0] data_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_APPEND,
		OP_ROTATE,
		OP_DROP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/ols_cmd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ols_cmd_if
// Request channel of the ordered list store: kind and value with valid/ready.
// ----------------------------------------------------------------------------
interface ols_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

[rtl/ols_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ols_rsp_if
// Result channel of the ordered list store with valid/ready.
// ----------------------------------------------------------------------------
interface ols_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] entry_value;
	logic [4:0]         entry_count;
	logic               last;

	modport source (output valid, output status, output entry_value,
		output entry_count, output last, input ready);
	modport sink   (input valid, input status, input entry_value,
		input entry_count, input last, output ready);
endinterface
`default_nettype wire

[rtl/ols_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ols_cell
// One storage cell of the list row. Holds one entry and loads from its left
// neighbor, its right neighbor, the head cell or the request value.
// ----------------------------------------------------------------------------
module ols_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 5
) (
	input  wire                      clk,
	input  wire ols_pkg::cell_ctrl_t ctrl,
	input  wire [CW-1:0]             count,
	input  wire ols_pkg::data_t      left_data,
	input  wire ols_pkg::data_t      right_data,
	input  wire ols_pkg::data_t      head_data,
	output ols_pkg::data_t           data
);

	localparam logic [CW-1:0] IdxC  = CW'(IDX);
	localparam logic [CW-1:0] NextC = CW'(IDX + 1);

	ols_pkg::data_t data_q;
	ols_pkg::data_t data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			ols_pkg::OP_PUSH_FRONT: begin
				data_d = (IDX == 0) ? ctrl.value : left_data;
			end
			ols_pkg::OP_APPEND: begin
				if (count == IdxC) begin
					data_d = ctrl.value;
				end
			end
			ols_pkg::OP_ROTATE: begin
				// the tail cell takes the head, all others move toward the front
				data_d = (count == NextC) ? head_data : right_data;
			end
			ols_pkg::OP_DROP: begin
				data_d = right_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

[rtl/ordered_list_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit values held in a row of cells that
// acts as a ring; inserts, delete of the first match and front-to-back listing.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  cmd      in   kind[1:0], value[31:0]                    valid/ready
//  rsp      out  status[2:0], entry_value[31:0],           valid/ready
//                entry_count[4:0], last
//
//  Insert and requests on an empty list: result loaded into the output register.
//  Delete: the ring rotates once through all entries in S_DEL, then S_DONE.
//  List: one result per rotation step of the cell ring.
//  Reset clears the count, state and output register; the cells need no clearing.
//  A stalled rsp pauses listing and the final delete result; cmd is taken
//  only with no request in progress and room in the output register.
// ----------------------------------------------------------------------------
module ordered_list_store #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire clk,
	input  wire arst_n,
	ols_cmd_if.sink   cmd,
	ols_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CapC = CW'(CAPACITY);
	localparam logic [CW-1:0] OneC = CW'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIST,
		S_DEL,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rem_q;
	logic                found_q;
	ols_pkg::data_t      key_q;
	logic                out_valid_q;
	logic [2:0]          out_status_q;
	ols_pkg::data_t      out_value_q;
	logic [4:0]          out_count_q;
	logic                out_last_q;

	ols_pkg::data_t      cell_data [CAPACITY];
	ols_pkg::cell_ctrl_t ctrl;
	ols_pkg::data_t      head;
	logic                can_push;
	logic                accept;
	logic                full;
	logic                match;
	logic                out_load;
	logic [CW-1:0]       count_inc;
	logic [CW-1:0]       count_dec;
	logic [CW+4:0]       count_x;
	logic [CW+4:0]       count_inc_x;

	assign head        = cell_data[0];
	assign can_push    = !out_valid_q || rsp.ready;
	assign cmd.ready   = (state_q == S_IDLE) && can_push;
	assign accept      = cmd.valid && cmd.ready;
	assign full        = (count_q == CapC);
	assign match       = (head == key_q) && !found_q;
	assign count_inc   = count_q + OneC;
	assign count_dec   = count_q - OneC;
	assign count_x     = (CW + 5)'(count_q);
	assign count_inc_x = (CW + 5)'(count_inc);

	always_comb begin
		ctrl.op    = ols_pkg::OP_HOLD;
		ctrl.value = cmd.value;
		case (state_q)
			S_IDLE: begin
				if (accept && !full) begin
					if (cmd.kind == ols_pkg::KIND_PUSH_FRONT) begin
						ctrl.op = ols_pkg::OP_PUSH_FRONT;
					end else if (cmd.kind == ols_pkg::KIND_PUSH_BACK) begin
						ctrl.op = ols_pkg::OP_APPEND;
					end
				end
			end
			S_LIST: begin
				if (can_push) begin
					ctrl.op = ols_pkg::OP_ROTATE;
				end
			end
			S_DEL: begin
				// a matching head leaves the ring, others go round to the tail
				ctrl.op = match ? ols_pkg::OP_DROP : ols_pkg::OP_ROTATE;
			end
			default: begin
				ctrl.op = ols_pkg::OP_HOLD;
			end
		endcase
	end

	// a new result enters the output register this cycle
	always_comb begin
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				out_load = accept && ((cmd.kind inside {ols_pkg::KIND_PUSH_FRONT,
					ols_pkg::KIND_PUSH_BACK}) || (count_q == '0));
			end
			S_LIST, S_DONE: begin
				out_load = can_push;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ols_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.left_data  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
			.right_data (cell_data[(i + 1) % CAPACITY]),
			.head_data  (head),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			found_q      <= 1'b0;
			key_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_value_q  <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							ols_pkg::KIND_PUSH_FRONT, ols_pkg::KIND_PUSH_BACK: begin
								out_value_q <= cmd.value;
								out_last_q  <= 1'b1;
								if (full) begin
									out_status_q <= ols_pkg::ST_FULL;
									out_count_q  <= count_x[4:0];
								end else begin
									out_status_q <= ols_pkg::ST_INSERTED;
									out_count_q  <= count_inc_x[4:0];
									count_q      <= count_inc;
								end
							end
							ols_pkg::KIND_DELETE: begin
								key_q   <= cmd.value;
								found_q <= 1'b0;
								if (count_q == '0) begin
									out_status_q <= ols_pkg::ST_NOTFOUND;
									out_value_q  <= cmd.value;
									out_count_q  <= count_x[4:0];
									out_last_q   <= 1'b1;
								end else begin
									rem_q   <= count_q;
									state_q <= S_DEL;
								end
							end
							default: begin
								if (count_q == '0) begin
									out_status_q <= ols_pkg::ST_EMPTY;
									out_value_q  <= '0;
									out_count_q  <= '0;
									out_last_q   <= 1'b1;
								end else begin
									rem_q   <= count_q;
									state_q <= S_LIST;
								end
							end
						endcase
					end
				end
				S_LIST: begin
					if (can_push) begin
						out_status_q <= ols_pkg::ST_LISTED;
						out_value_q  <= head;
						out_count_q  <= count_x[4:0];
						out_last_q   <= (rem_q == OneC);
						rem_q        <= rem_q - OneC;
						if (rem_q == OneC) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DEL: begin
					if (match) begin
						count_q <= count_dec;
						found_q <= 1'b1;
					end
					rem_q <= rem_q - OneC;
					if (rem_q == OneC) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (can_push) begin
						out_status_q <= found_q ? ols_pkg::ST_DELETED : ols_pkg::ST_NOTFOUND;
						out_value_q  <= key_q;
						out_count_q  <= count_x[4:0];
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last        = out_last_q;

	// count stays within the row of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CapC)
		else $error("list count above capacity");

	// a delete sweep never grows the list
	a_del_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL) |=> (count_q <= $past(count_q)))
		else $error("count grew during delete sweep");

	// a delete removes at most one entry
	a_del_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL) && found_q |=> (count_q == $past(count_q)))
		else $error("second entry removed in one delete");

	// a sweep always has steps left while it runs
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_LIST) || (state_q == S_DEL)) |-> (rem_q != '0))
		else $error("sweep running with no steps left");

endmodule
`default_nettype wire
